// ===== rtl/aarb_pkg.sv =====
// Shared types and constants for the antialiased ring / arc pixel blender.
`default_nettype none

package aarb_pkg;

	// Angle constants, Q3.13 radians
	localparam int ANG_PI         = 25736;
	localparam int ANG_HALF_PI    = 12868;
	localparam int ANG_3_HALF_PI  = 38604;
	localparam int ANG_TWO_PI     = 51472;

	localparam int CORDIC_STEPS = 14;
	localparam int ZW           = 18;   // CORDIC angle accumulator, signed
	localparam int CW           = 22;   // CORDIC x/y, signed

	// arctan(2^-i) in Q3.13
	localparam logic [12:0] ATAN [0:CORDIC_STEPS-1] = '{
		13'd6434, 13'd3798, 13'd2007, 13'd1019, 13'd511, 13'd256, 13'd128,
		13'd64, 13'd32, 13'd16, 13'd8, 13'd4, 13'd2, 13'd1
	};

	// Latencies
	localparam int CORDIC_LAT = CORDIC_STEPS + 2;
	localparam int DIV_LAT    = 8;
	localparam int LATENCY    = 29;

	// Config register indexes
	localparam logic [3:0] REG_CENTER_X   = 4'd0;
	localparam logic [3:0] REG_CENTER_Y   = 4'd1;
	localparam logic [3:0] REG_RADIUS     = 4'd2;
	localparam logic [3:0] REG_RING_WIDTH = 4'd3;
	localparam logic [3:0] REG_ARC_START  = 4'd4;
	localparam logic [3:0] REG_ARC_END    = 4'd5;
	localparam logic [3:0] REG_FILL_COLOR = 4'd6;
	localparam logic [3:0] REG_SRC_ALPHA  = 4'd7;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} dest_t;

	typedef struct packed {
		logic canvas;   // pixel inside canvas
		logic le_r;     // d^2 <= radius^2
		logic ge_in;    // inner test passes
	} flags_t;

endpackage

`default_nettype wire

// ===== rtl/aa_ring_arc_pixel_blend_top.sv =====
// Top level of the antialiased ring / disc / arc pixel shader with source-over blend.
`default_nettype none

// One pixel per clock; busy is always low, so a rasterizer may issue a beat
// on every cycle. The depth is set by the 14-step CORDIC angle unit (16
// stages with setup and wrap), run alongside a 13-stage bit-per-stage square
// root, followed by the coverage/alpha stage, the blend multipliers and an
// 8-stage divider per color channel. Each result appears on the result ports
// for one cycle with done high and must be taken then. Configuration is
// written through cfg_valid/cfg_index/cfg_data (cfg_ready is always high)
// while no pixel is in flight, which the block itself does not enforce;
// derived values (radius^2, inner radius^2) are registered from the config
// registers, inner radius^2 by way of a registered inner radius. Pixels
// with write_enable low return the destination unchanged.

module aa_ring_arc_pixel_blend_top #(
	parameter int CANVAS_SIZE = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// pixel beat
	input  wire logic        start,
	output logic             busy,
	input  wire logic [7:0]  pixel_x,
	input  wire logic [7:0]  pixel_y,
	input  wire logic [7:0]  dest_red,
	input  wire logic [7:0]  dest_green,
	input  wire logic [7:0]  dest_blue,
	input  wire logic [7:0]  dest_alpha,
	// result beat
	output logic             done,
	output logic             write_enable,
	output logic [7:0]       new_red,
	output logic [7:0]       new_green,
	output logic [7:0]       new_blue,
	output logic [7:0]       new_alpha,
	// config write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [3:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	localparam int LAT = aarb_pkg::LATENCY;

	//------------------------------------------------------------------
	// Config registers and derived constants
	//------------------------------------------------------------------
	logic [11:0] center_x_q, center_y_q, radius_q, ring_width_q;
	logic [15:0] arc_start_q, arc_end_q;
	logic [23:0] fill_color_q;
	logic [8:0]  src_alpha_q;
	logic [23:0] r2_q, inner2_q;
	logic signed [12:0] inner_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q   <= 12'd2048;
			center_y_q   <= 12'd2048;
			radius_q     <= '0;
			ring_width_q <= '0;
			arc_start_q  <= '0;
			arc_end_q    <= 16'(aarb_pkg::ANG_TWO_PI);
			fill_color_q <= '0;
			src_alpha_q  <= 9'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				aarb_pkg::REG_CENTER_X:   center_x_q   <= cfg_data[11:0];
				aarb_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data[11:0];
				aarb_pkg::REG_RADIUS:     radius_q     <= cfg_data[11:0];
				aarb_pkg::REG_RING_WIDTH: ring_width_q <= cfg_data[11:0];
				aarb_pkg::REG_ARC_START:  arc_start_q  <= cfg_data[15:0];
				aarb_pkg::REG_ARC_END:    arc_end_q    <= cfg_data[15:0];
				aarb_pkg::REG_FILL_COLOR: fill_color_q <= cfg_data;
				aarb_pkg::REG_SRC_ALPHA:  src_alpha_q  <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Squared radii, refreshed every cycle from the registers
	always_ff @(posedge clk) begin
		r2_q     <= 24'(radius_q * radius_q);
		inner_q  <= $signed({1'b0, radius_q}) - $signed({1'b0, ring_width_q});
		inner2_q <= 24'(inner_q[11:0] * inner_q[11:0]);
	end

	logic       inner_pos;
	logic       disc;
	logic [8:0] sa;
	assign inner_pos = !inner_q[12] && (inner_q != '0);
	assign disc      = (ring_width_q == '0);
	assign sa        = (src_alpha_q > 9'd256) ? 9'd256 : src_alpha_q;

	//------------------------------------------------------------------
	// Valid chain and carried fields
	//------------------------------------------------------------------
	logic                 vld_s  [1:LAT];
	aarb_pkg::dest_t      dest_s [1:LAT-1];
	aarb_pkg::flags_t     fl_s   [1:17];
	logic                 we_s   [18:LAT-1];
	logic [7:0]           na_s   [20:LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++)
				vld_s[i] <= 1'b0;
		end else begin
			vld_s[1] <= start && !busy;
			for (int i = 2; i <= LAT; i++)
				vld_s[i] <= vld_s[i-1];
		end
	end

	//------------------------------------------------------------------
	// s1: capture, offsets from centre
	//------------------------------------------------------------------
	logic signed [12:0] dx_s1, dy_s1;

	always_ff @(posedge clk) begin
		dest_s[1]        <= '{red: dest_red, green: dest_green,
		                      blue: dest_blue, alpha: dest_alpha};
		dx_s1            <= $signed({1'b0, pixel_x, 4'b0}) - $signed({1'b0, center_x_q});
		dy_s1            <= $signed({1'b0, pixel_y, 4'b0}) - $signed({1'b0, center_y_q});
		for (int i = 2; i < LAT; i++)
			dest_s[i] <= dest_s[i-1];
	end

	// Angle, ready at s17
	logic [15:0] angle_s17;
	aarb_cordic u_cordic (
		.clk   (clk),
		.dx    (dx_s1),
		.dy    (dy_s1),
		.angle (angle_s17)
	);

	//------------------------------------------------------------------
	// s2..s4: squared distance and radius tests
	//------------------------------------------------------------------
	logic [23:0] dxx_s2, dyy_s2;
	logic [24:0] sq_rem_s  [3:16];
	logic [12:0] sq_root_s [3:16];

	always_ff @(posedge clk) begin
		fl_s[1].canvas <= (13'(pixel_x) < 13'(CANVAS_SIZE)) &&
		                  (13'(pixel_y) < 13'(CANVAS_SIZE));
		fl_s[1].le_r   <= 1'b0;
		fl_s[1].ge_in  <= 1'b0;
		dxx_s2       <= 24'(dx_s1 * dx_s1);
		dyy_s2       <= 24'(dy_s1 * dy_s1);
		sq_rem_s[3]  <= 25'(dxx_s2) + 25'(dyy_s2);
		sq_root_s[3] <= '0;
		for (int i = 2; i <= 17; i++) begin
			if (i == 4) begin
				fl_s[i].canvas <= fl_s[i-1].canvas;
				fl_s[i].le_r   <= sq_rem_s[3] <= 25'(r2_q);
				fl_s[i].ge_in  <= !inner_pos || (sq_rem_s[3] >= 25'(inner2_q));
			end else begin
				fl_s[i] <= fl_s[i-1];
			end
		end
	end

	// Floor square root, one result bit per stage (s4..s16)
	for (genvar k = 4; k <= 16; k++) begin : g_sqrt
		localparam int B = 16 - k;
		logic [26:0] t;
		logic        ge;
		always_comb begin
			t  = (27'(sq_root_s[k-1]) << (B + 1)) + (27'd1 << (2 * B));
			ge = 27'(sq_rem_s[k-1]) >= t;
		end
		always_ff @(posedge clk) begin
			sq_rem_s[k]  <= ge ? sq_rem_s[k-1] - t[24:0] : sq_rem_s[k-1];
			sq_root_s[k] <= sq_root_s[k-1] | (ge ? (13'd1 << B) : 13'd0);
		end
	end

	//------------------------------------------------------------------
	// s17: edge coverage ramp
	//------------------------------------------------------------------
	logic signed [14:0] m1, m2, mm;
	logic [8:0]         cov_s17;

	always_comb begin
		m1 = $signed({3'b0, radius_q}) - $signed({2'b0, sq_root_s[16]});
		m2 = $signed({2'b0, sq_root_s[16]}) - 15'(inner_q);
		mm = (m1 < m2) ? m1 : m2;
	end

	always_ff @(posedge clk) begin
		cov_s17 <= (mm >= 15'sd8) ? 9'd256 : 9'(mm * 16 + 128);
	end

	//------------------------------------------------------------------
	// s18: arc window, coverage decision, effective alpha
	//------------------------------------------------------------------
	logic        arc_ok, covered;
	logic [8:0]  a_ring, a_eff;
	logic [8:0]  a_s18;

	always_comb begin
		arc_ok  = (angle_s17 >= arc_start_q) && (angle_s17 <= arc_end_q);
		covered = fl_s[17].canvas && fl_s[17].le_r && arc_ok &&
		          (disc || fl_s[17].ge_in);
		a_ring  = 9'((18'(sa) * 18'(cov_s17)) >> 8);
		a_eff   = covered ? (disc ? sa : a_ring) : 9'd0;
	end

	always_ff @(posedge clk) begin
		a_s18     <= a_eff;
		we_s[18]  <= a_eff != '0;
		for (int i = 19; i < LAT; i++)
			we_s[i] <= we_s[i-1];
	end

	//------------------------------------------------------------------
	// s19/s20: blend products, numerators and normalizer
	//------------------------------------------------------------------
	logic [7:0]  src_c [0:2];
	logic [7:0]  dst_c [0:2];
	logic [15:0] ca_s19 [0:2];
	logic [15:0] pd_s19 [0:2];
	logic [8:0]  ia_s19;
	logic [15:0] n_s19, n_s20;
	logic [24:0] num_s20 [0:2];
	logic [7:0]  quo [0:2];

	assign src_c[0] = fill_color_q[23:16];
	assign src_c[1] = fill_color_q[15:8];
	assign src_c[2] = fill_color_q[7:0];
	assign dst_c[0] = dest_s[18].red;
	assign dst_c[1] = dest_s[18].green;
	assign dst_c[2] = dest_s[18].blue;

	always_ff @(posedge clk) begin
		ia_s19 <= 9'd256 - a_s18;
		n_s19  <= 16'(17'(a_s18) * 17'd255 + 17'(dest_s[18].alpha) * 17'(9'd256 - a_s18));
		for (int c = 0; c < 3; c++) begin
			ca_s19[c]  <= 16'(src_c[c] * a_s18);
			pd_s19[c]  <= 16'(dst_c[c] * dest_s[18].alpha);
			num_s20[c] <= 25'({ca_s19[c], 8'b0}) - 25'(ca_s19[c]) +
			              25'(pd_s19[c] * ia_s19);
		end
		n_s20     <= n_s19;
		na_s[20]  <= n_s19[15:8];
		for (int i = 21; i < LAT; i++)
			na_s[i] <= na_s[i-1];
	end

	// s21..s28: per-channel divide by the normalizer
	for (genvar c = 0; c < 3; c++) begin : g_div
		aarb_div u_div (
			.clk (clk),
			.num (num_s20[c]),
			.den (n_s20),
			.quo (quo[c])
		);
	end

	//------------------------------------------------------------------
	// s29: result registers
	//------------------------------------------------------------------
	logic       we_q;
	logic [7:0] red_q, green_q, blue_q, alpha_q;

	always_ff @(posedge clk) begin
		we_q    <= we_s[LAT-1];
		red_q   <= we_s[LAT-1] ? quo[0] : dest_s[LAT-1].red;
		green_q <= we_s[LAT-1] ? quo[1] : dest_s[LAT-1].green;
		blue_q  <= we_s[LAT-1] ? quo[2] : dest_s[LAT-1].blue;
		alpha_q <= we_s[LAT-1] ? na_s[LAT-1] : dest_s[LAT-1].alpha;
	end

	assign done         = vld_s[LAT];
	assign write_enable = we_q;
	assign new_red      = red_q;
	assign new_green    = green_q;
	assign new_blue     = blue_q;
	assign new_alpha    = alpha_q;

endmodule

`default_nettype wire

// ===== rtl/aarb_cordic.sv =====
// Pipelined CORDIC vectoring unit: pixel offset to angle in Q3.13, 0..2pi.
`default_nettype none

module aarb_cordic (
	input  wire logic               clk,
	input  wire logic signed [12:0] dx,
	input  wire logic signed [12:0] dy,
	output logic             [15:0] angle
);

	localparam int N  = aarb_pkg::CORDIC_STEPS;
	localparam int ZW = aarb_pkg::ZW;
	localparam int CW = aarb_pkg::CW;
	localparam logic signed [ZW-1:0] Z_PI     = ZW'(aarb_pkg::ANG_PI);
	localparam logic signed [ZW-1:0] Z_TWO_PI = ZW'(aarb_pkg::ANG_TWO_PI);

	logic signed [CW-1:0] x_s  [0:N];
	logic signed [CW-1:0] y_s  [0:N];
	logic signed [ZW-1:0] z_s  [0:N];
	logic                 sp_s [0:N];
	logic        [15:0]   spa_s[0:N];
	logic        [15:0]   angle_q;

	logic signed [CW-1:0] xi, yi;
	logic signed [ZW-1:0] zi;
	logic                 spi;
	logic        [15:0]   spai;

	// Axis pixels take exact angles; left half-plane is rotated by pi.
	always_comb begin
		xi   = CW'({{(CW-19){dx[12]}}, dx, 6'b0});
		yi   = CW'({{(CW-19){dy[12]}}, dy, 6'b0});
		zi   = '0;
		spi  = 1'b0;
		spai = '0;
		if (dx[12]) begin
			xi = -xi;
			yi = -yi;
			zi = Z_PI;
		end
		if (dy == '0) begin
			spi  = 1'b1;
			spai = dx[12] ? 16'(aarb_pkg::ANG_PI) : 16'd0;
		end else if (dx == '0) begin
			spi  = 1'b1;
			spai = dy[12] ? 16'(aarb_pkg::ANG_3_HALF_PI) : 16'(aarb_pkg::ANG_HALF_PI);
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= xi;
		y_s[0]   <= yi;
		z_s[0]   <= zi;
		sp_s[0]  <= spi;
		spa_s[0] <= spai;
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [CW-1:0] xs, ys, xn, yn;
		logic signed [ZW-1:0] zn, at;
		always_comb begin
			xs = x_s[i] >>> i;
			ys = y_s[i] >>> i;
			at = $signed({{(ZW-13){1'b0}}, aarb_pkg::ATAN[i]});
			if (!y_s[i][CW-1]) begin
				xn = x_s[i] + ys;
				yn = y_s[i] - xs;
				zn = z_s[i] + at;
			end else begin
				xn = x_s[i] - ys;
				yn = y_s[i] + xs;
				zn = z_s[i] - at;
			end
		end
		always_ff @(posedge clk) begin
			x_s[i+1]   <= xn;
			y_s[i+1]   <= yn;
			z_s[i+1]   <= zn;
			sp_s[i+1]  <= sp_s[i];
			spa_s[i+1] <= spa_s[i];
		end
	end

	logic signed [ZW-1:0] zw;
	always_comb begin
		zw = z_s[N];
		if (zw < 0)
			zw = zw + Z_TWO_PI;
		else if (zw >= Z_TWO_PI)
			zw = zw - Z_TWO_PI;
	end

	always_ff @(posedge clk) begin
		angle_q <= sp_s[N] ? spa_s[N] : zw[15:0];
	end

	assign angle = angle_q;

endmodule

`default_nettype wire

// ===== rtl/aarb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, 8-bit quotient.
`default_nettype none

module aarb_div (
	input  wire logic        clk,
	input  wire logic [24:0] num,
	input  wire logic [15:0] den,
	output logic      [7:0]  quo
);

	localparam int N = aarb_pkg::DIV_LAT;

	logic [24:0] rem_s [0:N];
	logic [15:0] den_s [0:N];
	logic [7:0]  q_s   [0:N];

	assign rem_s[0] = num;
	assign den_s[0] = den;
	assign q_s[0]   = '0;

	for (genvar j = 0; j < N; j++) begin : g_bit
		localparam int B = N - 1 - j;
		logic [24:0] t;
		logic        ge;
		always_comb begin
			t  = 25'(den_s[j]) << B;
			ge = rem_s[j] >= t;
		end
		always_ff @(posedge clk) begin
			rem_s[j+1] <= ge ? rem_s[j] - t : rem_s[j];
			den_s[j+1] <= den_s[j];
			q_s[j+1]   <= q_s[j] | (ge ? (8'd1 << B) : 8'd0);
		end
	end

	assign quo = q_s[N];

endmodule

`default_nettype wire

// ===== rtl/aarb_checker.sv =====
// Port-level checker for the pixel blender, bound to the top level.
`default_nettype none

module aarb_props (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic [7:0] dest_red,
	input wire logic [7:0] dest_alpha,
	input wire logic       done,
	input wire logic       write_enable,
	input wire logic [7:0] new_red,
	input wire logic [7:0] new_alpha
);

	localparam int LAT = aarb_pkg::LATENCY;

	// Every accepted beat returns exactly after the pipeline depth
	a_beat_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without accepted beat");

	// Untouched pixels hand the destination back
	a_passthrough: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !write_enable) |->
			(new_red == $past(dest_red, LAT)) && (new_alpha == $past(dest_alpha, LAT)))
		else $error("unchanged pixel altered");

	// Source-over never lowers opacity
	a_alpha_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(done && write_enable) |-> (new_alpha >= $past(dest_alpha, LAT)))
		else $error("blend reduced alpha");

endmodule

bind aa_ring_arc_pixel_blend_top aarb_props u_aarb_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.dest_red     (dest_red),
	.dest_alpha   (dest_alpha),
	.done         (done),
	.write_enable (write_enable),
	.new_red      (new_red),
	.new_alpha    (new_alpha)
);

`default_nettype wire
